// ----- sv/ffc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the four-function calculator keypad unit.
// No dependencies; imported by every design module of the block.
package ffc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
    localparam int DECIMAL_BASE = 10;

    // Key kinds
    localparam logic [2:0] MODE_DIGIT  = 3'd0;
    localparam logic [2:0] MODE_OPER   = 3'd1;
    localparam logic [2:0] MODE_EQUALS = 3'd2;
    localparam logic [2:0] MODE_MPLUS  = 3'd3;
    localparam logic [2:0] MODE_MCLEAR = 3'd4;
    localparam logic [2:0] MODE_RECALL = 3'd5;
    localparam logic [2:0] MODE_CLEAR  = 3'd6;

    // Operator codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NONE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_start;
        logic div_finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } status_t;

endpackage

// ----- sv/ffc_div.sv -----
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on ffc_pkg.
module ffc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ffc_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [ffc_pkg::DATA_WIDTH-1:0] divisor,
    output logic [ffc_pkg::DATA_WIDTH-1:0] quotient,
    output logic                         done
);
    import ffc_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       rem_shift;
    logic [W:0]       diff;

    assign rem_shift = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            neg_next  = dividend[W-1] ^ divisor[W-1];
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            dvs_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;
    assign done     = done_reg;

endmodule

// ----- sv/ffc_dp.sv -----
`timescale 1ns / 1ps
// Datapath: key register, calculator state, arithmetic and output register.
// Depends on ffc_pkg and ffc_div.
module ffc_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ffc_pkg::cmd_t                  cmd,
    output ffc_pkg::status_t               status,
    input  logic [2:0]                     key_mode,
    input  logic [3:0]                     key_digit,
    input  logic [2:0]                     key_op,
    output logic [ffc_pkg::DATA_WIDTH-1:0] out_display,
    output logic [ffc_pkg::DATA_WIDTH-1:0] out_memory,
    output logic                           out_error
);
    import ffc_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [2:0]   mode_reg;
    logic [3:0]   digit_reg;
    logic [2:0]   opc_reg;
    logic [W-1:0] shown_reg, shown_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] mem_reg, mem_next;
    logic [2:0]   pend_reg, pend_next;
    logic         err_reg, err_next;
    logic [W-1:0] disp_out_reg, mem_out_reg;
    logic         err_out_reg;

    logic [W-1:0] product;
    logic [W-1:0] decimal;
    logic [W-1:0] eq_result;
    logic [W-1:0] div_q;
    logic         div_done;
    logic         resolve;

    assign product = W'(acc_reg * shown_reg);
    assign decimal = W'(shown_reg * W'(DECIMAL_BASE)) + W'(digit_reg);

    assign resolve = (mode_reg == MODE_EQUALS) ||
                     ((mode_reg == MODE_OPER) && (pend_reg <= OP_DIV));

    assign status.need_div = resolve && (pend_reg == OP_DIV) && !err_reg &&
                             (shown_reg != '0);
    assign status.div_done = div_done;

    ffc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (shown_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb begin
        case (pend_reg)
            OP_ADD:  eq_result = acc_reg + shown_reg;
            OP_SUB:  eq_result = acc_reg - shown_reg;
            OP_MUL:  eq_result = product;
            default: eq_result = shown_reg;
        endcase
    end

    always_comb begin
        shown_next = shown_reg;
        acc_next   = acc_reg;
        mem_next   = mem_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        if (cmd.exec) begin
            case (mode_reg)
                MODE_DIGIT: shown_next = decimal;
                MODE_OPER, MODE_EQUALS: begin
                    if (resolve) begin
                        if (err_reg) begin
                            shown_next = '0;
                            acc_next   = '0;
                        end else begin
                            // only a zero divisor reaches here with a divide pending
                            if (pend_reg == OP_DIV) err_next = 1'b1;
                            shown_next = eq_result;
                            acc_next   = eq_result;
                            pend_next  = OP_NONE;
                        end
                    end else begin
                        acc_next = shown_reg;
                    end
                    if ((mode_reg == MODE_OPER) && !err_next) begin
                        shown_next = '0;
                        pend_next  = opc_reg;
                    end
                end
                MODE_MPLUS:  mem_next = mem_reg + shown_reg;
                MODE_MCLEAR: mem_next = '0;
                MODE_RECALL: shown_next = mem_reg;
                MODE_CLEAR: begin
                    shown_next = '0;
                    acc_next   = '0;
                    mem_next   = '0;
                    pend_next  = OP_NONE;
                    err_next   = 1'b0;
                end
                default: ;
            endcase
        end else if (cmd.div_finish) begin
            acc_next   = div_q;
            shown_next = div_q;
            pend_next  = OP_NONE;
            if (mode_reg == MODE_OPER) begin
                shown_next = '0;
                pend_next  = opc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg <= '0;
            acc_reg   <= '0;
            mem_reg   <= '0;
            pend_reg  <= OP_NONE;
            err_reg   <= 1'b0;
        end else begin
            shown_reg <= shown_next;
            acc_reg   <= acc_next;
            mem_reg   <= mem_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
        end
        if (cmd.latch) begin
            mode_reg  <= key_mode;
            digit_reg <= key_digit;
            opc_reg   <= (key_op > OP_NONE) ? OP_NONE : key_op;
        end
        if (cmd.load_out) begin
            disp_out_reg <= shown_reg;
            mem_out_reg  <= mem_reg;
            err_out_reg  <= err_reg;
        end
    end

    assign out_display = disp_out_reg;
    assign out_memory  = mem_out_reg;
    assign out_error   = err_out_reg;

endmodule

// ----- sv/ffc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences latch, execute, divide and output load per key word.
// Depends on ffc_pkg.
module ffc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ffc_pkg::status_t  status,
    output ffc_pkg::cmd_t     cmd
);
    import ffc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = status.need_div ? ST_DIV : ST_PUSH;
            ST_DIV:  if (status.div_done) state_next = ST_PUSH;
            ST_PUSH: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            ST_EXEC: begin
                cmd.div_start = status.need_div;
                cmd.exec      = !status.need_div;
            end
            ST_DIV:  cmd.div_finish = status.div_done;
            ST_PUSH: cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- sv/four_function_calculator_keypad_unit.sv -----
`timescale 1ns / 1ps
// Four-function calculator keypad unit with one memory register.
// Depends on ffc_pkg, ffc_ctrl, ffc_dp.
//
// Usage:
//   Slave channel: one key press per word (mode, digit, operator code).
//   Master channel: one result word per key: display and memory in tdata,
//   error flag in tuser.
//   A key word is taken only in the idle state; one key is in flight at a time.
//   Each key passes through the idle (latch), execute and push states; a resolved
//   divide also waits in the divide state on the 32-step shift-subtract divider.
//   The push state waits out any output stall before the next key is taken.
//   The result sits in an output register, so the next key is accepted while
//   the previous result waits; a new result is held back until that register
//   is taken.
//   Reset (aresetn low, synchronous) clears display, accumulator, memory and
//   error, leaves no operator pending and drops m_tvalid.
//   While m_tready is low, m_tvalid and the result word hold steady.
module four_function_calculator_keypad_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[2:0], digit_value[6:3], operator_code[9:7], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // display_value[31:0], memory_value[63:32]
    output logic [0:0]  m_tuser    // error_flag[0]
);
    import ffc_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [DATA_WIDTH-1:0] disp;
    logic [DATA_WIDTH-1:0] mem;
    logic err;

    ffc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .key_mode    (s_tdata[2:0]),
        .key_digit   (s_tdata[6:3]),
        .key_op      (s_tdata[9:7]),
        .out_display (disp),
        .out_memory  (mem),
        .out_error   (err)
    );

    assign m_tdata = {mem, disp};
    assign m_tuser = err;

endmodule

// ----- sv/ffc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the calculator keypad unit, bound to the top level.
// No package dependency.
module ffc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the channels");

    // one key in flight: no accept while the key passes through the execute state and the state after it
    a_one_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("key accepted while previous key still executing");

    // a result needs a key: none can appear right after the key is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without execution");

endmodule

bind four_function_calculator_keypad_unit ffc_checker u_ffc_checker (.*);
